### hdl/sbeq_pkg.sv
// Shared types and constants for the stereo cascaded biquad equaliser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sbeq_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned DEF_NUM_BANDS   = 6;
  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned DEF_COEF_BITS   = 32;

  // Coefficients are Q5.x: one sign bit and five integer bits
  localparam int unsigned COEF_INT_BITS = 6;
  localparam int unsigned NUM_COEFS     = 5;

  // Fixed field widths of the input item
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned BAND_FLD_W  = 3;
  localparam int unsigned COEF_IDX_W  = 3;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FRAME = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EFFECT_ENABLE = 2'd0,
    REG_BAND_MASK     = 2'd1
  } cfg_reg_e;

  // Biquad taps, in coefficient-table order
  typedef enum logic [COEF_IDX_W-1:0] {
    TAP_B0 = 3'd0,
    TAP_B1 = 3'd1,
    TAP_B2 = 3'd2,
    TAP_A1 = 3'd3,
    TAP_A2 = 3'd4
  } tap_e;

  // Sequencer to lane control
  typedef struct packed {
    logic load;       // take new frame samples
    logic clear;      // zero all delay lines
    logic mul_en;     // issue one multiply
    logic acc_first;  // accumulator takes first product plus rounding bias
    logic acc_add;    // accumulator adds product
    logic fin;        // round, saturate, update history
    tap_e tap;
  } lane_ctrl_t;

endpackage

### hdl/sbeq_if.sv
// Handshake channel interfaces: input items, result items, configuration writes.
// Depends on sbeq_pkg.
`timescale 1ns / 1ps

interface sbeq_in_if import sbeq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          end_of_block;
  logic [BAND_FLD_W-1:0]         band;
  logic [COEF_IDX_W-1:0]         coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  modport source (
    output valid, kind, left_sample, right_sample, end_of_block, band, coef_index,
           coef_value,
    input  ready
  );
  modport sink (
    input  valid, kind, left_sample, right_sample, end_of_block, band, coef_index,
           coef_value,
    output ready
  );
endinterface

interface sbeq_out_if import sbeq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          last_of_block;

  modport source (output valid, left_out, right_out, last_of_block, input ready);
  modport sink   (input  valid, left_out, right_out, last_of_block, output ready);
endinterface

interface sbeq_cfg_if import sbeq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### hdl/stereo_cascaded_biquad_equalizer_core.sv
// Top level of the stereo cascaded biquad equaliser: sequencer, two lanes, merge stage.
// Depends on sbeq_pkg, sbeq_if, sbeq_ctrl, sbeq_lane and sbeq_merge.
//
// Usage:
//   in_if  carries one item per beat: an audio frame (left/right sample and block
//          marker), a coefficient write (band, index, Q5.26 value) or a clear of all
//          delay lines. out_if returns one result beat per audio frame only.
//   cfg_if writes effect_enable (index 0) and band_active_mask (index 1); it is
//          always ready and should only be used while the block is idle.
// Sequencing:
//   Each lane owns one multiplier and steps through the five taps of each active band,
//   then rounds, saturates and updates that band's history; a masked band is skipped.
//   A frame is processed band by band and its result goes to the merge register before
//   the next item is taken. With the effect off a frame goes straight to that register.
//   Coefficient writes and clears leave the sequencer idle, so the next item can
//   follow straight away.
// Reset: coefficients return to unity pass (b0 = 1.0), histories clear, the effect
//   and all bands are enabled, and no result is pending.
// Stall: the result register holds while out_if.ready is low; one further item may
//   be accepted and processed, but its result waits until the register frees.
`timescale 1ns / 1ps

module stereo_cascaded_biquad_equalizer_core import sbeq_pkg::*; #(
  parameter int unsigned NUM_BANDS   = DEF_NUM_BANDS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbeq_in_if.sink    in_if,
  sbeq_out_if.source out_if,
  sbeq_cfg_if.sink   cfg_if
);

  localparam int unsigned BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  lane_ctrl_t                    lane_ctrl;
  logic [BAND_W-1:0]             band;
  logic signed [COEF_BITS-1:0]   coef;
  logic                          push;
  logic                          last;
  logic                          slot_free;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  // Configuration writes are always taken
  assign cfg_if.ready = 1'b1;

  sbeq_ctrl #(
    .NUM_BANDS (NUM_BANDS),
    .COEF_BITS (COEF_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_we_i    (cfg_if.valid),
    .cfg_index_i (cfg_if.index),
    .cfg_data_i  (cfg_if.data),
    .slot_free_i (slot_free),
    .lane_ctrl_o (lane_ctrl),
    .band_o      (band),
    .coef_o      (coef),
    .push_o      (push),
    .last_o      (last)
  );

  // Left lane
  sbeq_lane #(
    .NUM_BANDS   (NUM_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .band_i   (band),
    .coef_i   (coef),
    .sample_i (in_if.left_sample),
    .sample_o (left_res)
  );

  // Right lane
  sbeq_lane #(
    .NUM_BANDS   (NUM_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .band_i   (band),
    .coef_i   (coef),
    .sample_i (in_if.right_sample),
    .sample_o (right_res)
  );

  sbeq_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .left_i      (left_res),
    .right_i     (right_res),
    .last_i      (last),
    .slot_free_o (slot_free),
    .out_if      (out_if)
  );

endmodule

### hdl/sbeq_lane.sv
// One channel lane: shared multiplier, accumulator, round/saturate, per-band history.
// Depends on sbeq_pkg; driven by sbeq_ctrl.
`timescale 1ns / 1ps

module sbeq_lane import sbeq_pkg::*; #(
  parameter int unsigned NUM_BANDS   = DEF_NUM_BANDS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned COEF_BITS   = DEF_COEF_BITS,
  localparam int unsigned BAND_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctrl_t                    ctrl_i,
  input  logic [BAND_W-1:0]             band_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned FRAC   = COEF_BITS - COEF_INT_BITS;
  localparam int unsigned OP_W   = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = COEF_BITS + OP_W;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned SH_W   = ACC_W - FRAC;

  localparam logic signed [ACC_W-1:0] RND_BIAS =
    {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] xh1_q [NUM_BANDS];
  logic signed [SAMPLE_BITS-1:0] xh2_q [NUM_BANDS];
  logic signed [SAMPLE_BITS-1:0] yh1_q [NUM_BANDS];
  logic signed [SAMPLE_BITS-1:0] yh2_q [NUM_BANDS];
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [OP_W-1:0]        op;
  logic signed [ACC_W-1:0]       sum;
  logic signed [SH_W-1:0]        shifted;
  logic                          ovf;
  logic signed [SAMPLE_BITS-1:0] y;

  // Operand select; feedback taps enter negated so the sum only ever adds
  always_comb begin
    unique case (ctrl_i.tap)
      TAP_B0:  op = OP_W'(x_q);
      TAP_B1:  op = OP_W'(xh1_q[band_i]);
      TAP_B2:  op = OP_W'(xh2_q[band_i]);
      TAP_A1:  op = -OP_W'(yh1_q[band_i]);
      TAP_A2:  op = -OP_W'(yh2_q[band_i]);
      default: op = '0;
    endcase
  end

  assign prod_d = coef_i * op;

  // Round half up (bias preloaded), floor shift, saturate
  assign sum     = acc_q + ACC_W'(prod_q);
  assign shifted = sum[ACC_W-1:FRAC];
  assign ovf     = (shifted[SH_W-1:SAMPLE_BITS-1] != '0) &&
                   (shifted[SH_W-1:SAMPLE_BITS-1] != '1);
  assign y       = ovf ? (shifted[SH_W-1] ? SAT_MIN : SAT_MAX)
                       : shifted[SAMPLE_BITS-1:0];

  // Multiplier register and accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.acc_first) begin
      acc_q <= ACC_W'(prod_q) + RND_BIAS;
    end else if (ctrl_i.acc_add) begin
      acc_q <= sum;
    end
  end

  // Running sample and delay lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      for (int b = 0; b < NUM_BANDS; b++) begin
        xh1_q[b] <= '0;
        xh2_q[b] <= '0;
        yh1_q[b] <= '0;
        yh2_q[b] <= '0;
      end
    end else begin
      if (ctrl_i.load) begin
        x_q <= sample_i;
      end else if (ctrl_i.fin) begin
        x_q           <= y;
        xh1_q[band_i] <= x_q;
        xh2_q[band_i] <= xh1_q[band_i];
        yh1_q[band_i] <= y;
        yh2_q[band_i] <= yh1_q[band_i];
      end
      if (ctrl_i.clear) begin
        for (int b = 0; b < NUM_BANDS; b++) begin
          xh1_q[b] <= '0;
          xh2_q[b] <= '0;
          yh1_q[b] <= '0;
          yh2_q[b] <= '0;
        end
      end
    end
  end

  assign sample_o = x_q;

endmodule

### hdl/sbeq_ctrl.sv
// Sequencer: input handshake, configuration registers, coefficient table, band/tap steps.
// Depends on sbeq_pkg and sbeq_if; drives both sbeq_lane instances.
`timescale 1ns / 1ps

module sbeq_ctrl import sbeq_pkg::*; #(
  parameter int unsigned NUM_BANDS = DEF_NUM_BANDS,
  parameter int unsigned COEF_BITS = DEF_COEF_BITS,
  localparam int unsigned BAND_W   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sbeq_in_if.sink                     in_if,
  input  logic                        cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                        slot_free_i,
  output lane_ctrl_t                  lane_ctrl_o,
  output logic [BAND_W-1:0]           band_o,
  output logic signed [COEF_BITS-1:0] coef_o,
  output logic                        push_o,
  output logic                        last_o
);

  localparam int unsigned FRAC = COEF_BITS - COEF_INT_BITS;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE =
    {{(COEF_BITS-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic [2:0] PH_ACC_FIRST = 3'd1;
  localparam logic [2:0] PH_ACC_LAST  = 3'd4;
  localparam logic [2:0] PH_FIN       = 3'd5;
  localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_e;

  state_e                      state_q;
  logic [BAND_W-1:0]           band_q;
  logic [2:0]                  ph_q;
  logic                        last_q;
  logic                        enable_q;
  logic [NUM_BANDS-1:0]        mask_q;
  logic signed [COEF_BITS-1:0] coef_q [NUM_BANDS][NUM_COEFS];

  logic  accept;
  kind_e kind;
  logic  active;
  logic  run_act;
  logic  coef_wr;

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign kind        = kind_e'(in_if.kind);
  assign active      = mask_q[band_q];
  assign run_act     = (state_q == ST_RUN) && active;
  assign coef_wr     = accept && (kind == KIND_COEF) &&
                       (int'(in_if.band) < NUM_BANDS) &&
                       (in_if.coef_index < COEF_IDX_W'(NUM_COEFS));

  // Lane control for the current band step
  always_comb begin
    lane_ctrl_o.load      = accept && (kind == KIND_FRAME);
    lane_ctrl_o.clear     = accept && (kind == KIND_CLEAR);
    lane_ctrl_o.mul_en    = run_act && (ph_q <= PH_ACC_LAST);
    lane_ctrl_o.acc_first = run_act && (ph_q == PH_ACC_FIRST);
    lane_ctrl_o.acc_add   = run_act && (ph_q > PH_ACC_FIRST) && (ph_q <= PH_ACC_LAST);
    lane_ctrl_o.fin       = run_act && (ph_q == PH_FIN);
    lane_ctrl_o.tap       = tap_e'(ph_q);
  end

  assign band_o = band_q;
  assign coef_o = (ph_q <= PH_ACC_LAST) ? coef_q[band_q][ph_q] : '0;
  assign push_o = (state_q == ST_FIN) && slot_free_i;
  assign last_o = last_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      band_q  <= '0;
      ph_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (kind == KIND_FRAME)) begin
            last_q  <= in_if.end_of_block;
            band_q  <= '0;
            ph_q    <= '0;
            state_q <= enable_q ? ST_RUN : ST_FIN;
          end
        end
        ST_RUN: begin
          if (!active || (ph_q == PH_FIN)) begin
            ph_q <= '0;
            if (band_q == LAST_BAND) begin
              state_q <= ST_FIN;
            end else begin
              band_q <= band_q + 1'b1;
            end
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (slot_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      mask_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EFFECT_ENABLE: enable_q <= cfg_data_i[0];
        REG_BAND_MASK:     mask_q   <= cfg_data_i[NUM_BANDS-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient table, shared by both lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        for (int k = 0; k < NUM_COEFS; k++) begin
          coef_q[b][k] <= (k == 0) ? COEF_ONE : '0;
        end
      end
    end else if (coef_wr) begin
      coef_q[BAND_W'(in_if.band)][in_if.coef_index] <= in_if.coef_value;
    end
  end

endmodule

### hdl/sbeq_merge.sv
// Merging stage: joins the two lane results and the block marker into the output register.
// Depends on sbeq_pkg and sbeq_if.
`timescale 1ns / 1ps

module sbeq_merge import sbeq_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  input  logic                          last_i,
  output logic                          slot_free_o,
  sbeq_out_if.source                    out_if
);

  logic                          valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;
  logic                          last_q;

  assign slot_free_o = !valid_q || out_if.ready;

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      left_q  <= left_i;
      right_q <= right_i;
      last_q  <= last_i;
    end
  end

  assign out_if.valid         = valid_q;
  assign out_if.left_out      = left_q;
  assign out_if.right_out     = right_q;
  assign out_if.last_of_block = last_q;

endmodule

### hdl/sbeq_checker.sv
// Port-level checks for the equaliser top level, and the bind that attaches them.
// Depends on sbeq_pkg and stereo_cascaded_biquad_equalizer_core.
`timescale 1ns / 1ps

module sbeq_checker import sbeq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KIND_W-1:0] in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              cfg_ready_i
);

  // A frame beat occupies the block: no new item next cycle
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KIND_FRAME)) |=> !in_ready_i)
    else $error("input ready after frame beat");

  // Writes, clears and reserved beats leave the input ready in the next cycle
  a_ctrl_item_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i != KIND_FRAME)) |=> in_ready_i)
    else $error("input stalled after non-frame beat");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

endmodule

bind stereo_cascaded_biquad_equalizer_core sbeq_checker u_sbeq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_kind_i   (in_if.kind),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .cfg_ready_i (cfg_if.ready)
);

### bench/tb_stereo_cascaded_biquad_equalizer_core.sv
// Self-checking bench for the stereo cascaded biquad equaliser core: directed and
// random beats, checked against a bit-exact predictor of the six-band cascade.
// Depends on sbeq_pkg, sbeq_if and the core RTL.
`timescale 1ns / 1ps

module tb_stereo_cascaded_biquad_equalizer_core;
  import sbeq_pkg::*;

  localparam int     NB           = DEF_NUM_BANDS;
  localparam int     COEF_FRAC    = DEF_COEF_BITS - COEF_INT_BITS;
  localparam longint ONE_Q        = 64'sd1 <<< COEF_FRAC;
  localparam longint HALF_Q       = ONE_Q / 2;
  localparam longint A2_SPAN      = (ONE_Q * 6) / 10;
  localparam longint ROUND_BIAS   = 64'sd1 <<< (COEF_FRAC - 1);
  localparam longint S_MAX        = (64'sd1 <<< (DEF_SAMPLE_BITS - 1)) - 1;
  localparam longint S_MIN        = -(64'sd1 <<< (DEF_SAMPLE_BITS - 1));
  localparam longint C_MAX        = (64'sd1 <<< (DEF_COEF_BITS - 1)) - 1;
  localparam longint C_MIN        = -(64'sd1 <<< (DEF_COEF_BITS - 1));
  localparam int     BAND_FLD_TOP = (1 << BAND_FLD_W) - 1;
  localparam int     TAP_FLD_TOP  = (1 << COEF_IDX_W) - 1;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd2;
  localparam int     NUM_PHASES   = 7;
  localparam int     PHASE_ITEMS  = 107;
  localparam int     DRAIN_CYCLES = 50;
  localparam int     MAX_PRINTS   = 40;
  localparam longint LIMIT_NS     = 2_000_000;

  typedef struct {
    kind_e                            kind;
    logic signed [DEF_SAMPLE_BITS-1:0] left;
    logic signed [DEF_SAMPLE_BITS-1:0] right;
    logic                             eob;
    logic [BAND_FLD_W-1:0]            band;
    logic [COEF_IDX_W-1:0]            tap;
    logic signed [DEF_COEF_BITS-1:0]  coef;
  } eq_item_t;

  typedef struct {
    logic signed [DEF_SAMPLE_BITS-1:0] left;
    logic signed [DEF_SAMPLE_BITS-1:0] right;
    logic                             last;
  } eq_frame_t;

  logic clk;
  logic rst_n;

  sbeq_in_if  in_ch ();
  sbeq_out_if out_ch ();
  sbeq_cfg_if cfg_ch ();

  stereo_cascaded_biquad_equalizer_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor state: coefficients, delay lines and register copies
  longint     coef_tbl [NB][NUM_COEFS];
  longint     x_hist   [NB][2][2];
  longint     y_hist   [NB][2][2];
  bit         fx_enable;
  bit [NB-1:0] band_mask;

  eq_item_t  stim_q[$];
  eq_frame_t frame_q[$];

  bit [15:0] sink_pat;
  int        sink_left;
  int        burst_left;
  int        gap_left;
  bit        in_beat_taken;
  int        cfg_beats;
  int        mismatches;
  int        frames_checked;
  int        work_items;
  int        coef_writes;
  int        clears;
  int        ignored_items;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout
  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d beats still queued and %0d frames outstanding",
             stim_q.size(), frame_q.size());
    $display("** stereo_cascaded_biquad_equalizer_core: FAILED **");
    $finish;
  end

  function automatic void reset_model();
    for (int b = 0; b < NB; b++) begin
      for (int k = 0; k < NUM_COEFS; k++) coef_tbl[b][k] = (k == TAP_B0) ? ONE_Q : 0;
    end
    clear_delay_lines();
    fx_enable = 1'b1;
    band_mask = '1;
  endfunction

  function automatic void clear_delay_lines();
    for (int b = 0; b < NB; b++) begin
      for (int ch = 0; ch < 2; ch++) begin
        for (int t = 0; t < 2; t++) begin
          x_hist[b][ch][t] = 0;
          y_hist[b][ch][t] = 0;
        end
      end
    end
  endfunction

  // One direct-form-I step: exact sum, round half up, saturate, shift history
  function automatic longint biquad_tick(int b, int ch, longint x);
    longint acc;
    acc = coef_tbl[b][TAP_B0] * x
        + coef_tbl[b][TAP_B1] * x_hist[b][ch][0]
        + coef_tbl[b][TAP_B2] * x_hist[b][ch][1]
        - coef_tbl[b][TAP_A1] * y_hist[b][ch][0]
        - coef_tbl[b][TAP_A2] * y_hist[b][ch][1];
    acc = (acc + ROUND_BIAS) >>> COEF_FRAC;
    if (acc > S_MAX) acc = S_MAX;
    else if (acc < S_MIN) acc = S_MIN;
    x_hist[b][ch][1] = x_hist[b][ch][0];
    x_hist[b][ch][0] = x;
    y_hist[b][ch][1] = y_hist[b][ch][0];
    y_hist[b][ch][0] = acc;
    return acc;
  endfunction

  // Works out what one accepted beat does to the state and to the result stream
  function automatic void equalise_item(eq_item_t it);
    longint    l;
    longint    r;
    eq_frame_t res;
    case (it.kind)
      KIND_FRAME: begin
        l = longint'(it.left);
        r = longint'(it.right);
        if (fx_enable) begin
          for (int b = 0; b < NB; b++) begin
            if (band_mask[b]) begin
              l = biquad_tick(b, 0, l);
              r = biquad_tick(b, 1, r);
            end
          end
        end
        res.left  = l[DEF_SAMPLE_BITS-1:0];
        res.right = r[DEF_SAMPLE_BITS-1:0];
        res.last  = it.eob;
        frame_q.push_back(res);
      end
      KIND_COEF: begin
        if (it.band < NB && it.tap < NUM_COEFS)
          coef_tbl[it.band][it.tap] = longint'(it.coef);
      end
      KIND_CLEAR: clear_delay_lines();
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: frame %0d: %s: got %0d, expected %0d",
               $time, frames_checked, what, got, want);
    mismatches++;
  endtask

  // Item builders; unused fields carry random bits
  function automatic eq_item_t blank_item(kind_e k);
    eq_item_t it;
    it.kind  = k;
    it.left  = DEF_SAMPLE_BITS'($urandom);
    it.right = DEF_SAMPLE_BITS'($urandom);
    it.eob   = 1'($urandom);
    it.band  = BAND_FLD_W'($urandom);
    it.tap   = COEF_IDX_W'($urandom);
    it.coef  = DEF_COEF_BITS'($urandom);
    return it;
  endfunction

  function automatic eq_item_t frame_of(longint l, longint r, bit eob);
    eq_item_t it;
    it       = blank_item(KIND_FRAME);
    it.left  = l[DEF_SAMPLE_BITS-1:0];
    it.right = r[DEF_SAMPLE_BITS-1:0];
    it.eob   = eob;
    return it;
  endfunction

  function automatic eq_item_t coef_of(int b, int k, longint v);
    eq_item_t it;
    it      = blank_item(KIND_COEF);
    it.band = BAND_FLD_W'(b);
    it.tap  = COEF_IDX_W'(k);
    it.coef = v[DEF_COEF_BITS-1:0];
    return it;
  endfunction

  function automatic longint rand_sample();
    logic signed [DEF_SAMPLE_BITS-1:0] s;
    longint amp;
    if ($urandom_range(0, 9) < 3) begin
      s = DEF_SAMPLE_BITS'($urandom);
      return longint'(s);
    end
    amp = 64'sd1 <<< $urandom_range(6, 20);
    return longint'($urandom_range(0, 32'(2 * amp))) - amp;
  endfunction

  function automatic longint rand_signed(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  task automatic add_item(eq_item_t it);
    stim_q.push_back(it);
    if (it.kind == KIND_RSVD || (it.kind == KIND_COEF && (it.band >= NB ||
        it.tap >= NUM_COEFS))) ignored_items++;
    else work_items++;
    if (it.kind == KIND_COEF) coef_writes++;
    if (it.kind == KIND_CLEAR) clears++;
  endtask

  // Stable band: |a2| < 0.6, |a1| <= 0.9 * (1 + a2), feed-forward within +/- 0.5
  task automatic program_stable_band(int b);
    longint a1;
    longint a2;
    a2 = rand_signed(A2_SPAN);
    a1 = rand_signed(((ONE_Q + a2) * 9) / 10);
    add_item(coef_of(b, TAP_B0, rand_signed(HALF_Q)));
    add_item(coef_of(b, TAP_B1, rand_signed(HALF_Q)));
    add_item(coef_of(b, TAP_B2, rand_signed(HALF_Q)));
    add_item(coef_of(b, TAP_A1, a1));
    add_item(coef_of(b, TAP_A2, a2));
  endtask

  task automatic frame_block(int n);
    for (int i = 0; i < n; i++) add_item(frame_of(rand_sample(), rand_sample(), i == n - 1));
  endtask

  // Noise: any kind, out-of-range writes, extreme coefficients
  task automatic noise_burst(int n);
    eq_item_t it;
    for (int i = 0; i < n; i++) begin
      it = blank_item(kind_e'($urandom_range(0, 3)));
      if (it.kind == KIND_COEF && $urandom_range(0, 1))
        it.coef = DEF_COEF_BITS'($urandom_range(0, 1) ? C_MAX : C_MIN);
      add_item(it);
    end
  endtask

  task automatic random_phase(int goal);
    int start;
    start = work_items;
    while (work_items - start < goal) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          program_stable_band($urandom_range(0, NB - 1));
          if ($urandom_range(0, 1)) program_stable_band($urandom_range(0, NB - 1));
        end
        8: begin
          add_item(blank_item(KIND_CLEAR));
          frame_block($urandom_range(1, 3));
        end
        9: noise_burst($urandom_range(1, 4));
        default: frame_block($urandom_range(2, 12));
      endcase
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    int seen;
    seen = cfg_beats;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    wait (cfg_beats != seen);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_setting(bit en, bit [NB-1:0] mask);
    logic [CFG_DATA_W-1:0] d;
    d    = CFG_DATA_W'($urandom);
    d[0] = en;
    write_reg(REG_EFFECT_ENABLE, d);
    d         = CFG_DATA_W'($urandom);
    d[NB-1:0] = mask;
    write_reg(REG_BAND_MASK, d);
  endtask

  // Idle: everything sent, every frame back, then room for a trailing write or clear
  task automatic drain();
    wait (stim_q.size() == 0 && !in_ch.valid);
    wait (frame_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Input driver: bursts of random length separated by random gaps
  always @(negedge clk) begin : drive_in
    eq_item_t nxt;
    if (rst_n) begin
      if (!in_ch.valid || in_beat_taken) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (stim_q.size() != 0) begin
          nxt                = stim_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= nxt.kind;
          in_ch.left_sample  <= nxt.left;
          in_ch.right_sample <= nxt.right;
          in_ch.end_of_block <= nxt.eob;
          in_ch.band         <= nxt.band;
          in_ch.coef_index   <= nxt.tap;
          in_ch.coef_value   <= nxt.coef;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      in_beat_taken = 1'b0;
    end
  end

  // Result ready: rotating 16-bit pattern, periodically reloaded with a new random one
  always @(negedge clk) begin : drive_ready
    bit [15:0] pat;
    if (rst_n) begin
      if (sink_left == 0) begin
        case ($urandom_range(0, 3))
          0:       pat = '1;
          1:       pat = 16'($urandom);
          2:       pat = 16'($urandom | $urandom);
          default: pat = 16'($urandom & $urandom);
        endcase
        pat[0]       = 1'b1;
        sink_pat     <= pat;
        sink_left    <= 63;
        out_ch.ready <= pat[0];
      end else begin
        sink_pat     <= {sink_pat[0], sink_pat[15:1]};
        sink_left    <= sink_left - 1;
        out_ch.ready <= sink_pat[1];
      end
    end
  end

  // Input monitor: register writes and accepted beats feed the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_EFFECT_ENABLE: fx_enable = cfg_ch.data[0];
          REG_BAND_MASK:     band_mask = cfg_ch.data[NB-1:0];
          default: ;
        endcase
        cfg_beats++;
      end
      if (in_ch.valid && in_ch.ready) begin
        equalise_item('{kind_e'(in_ch.kind), in_ch.left_sample, in_ch.right_sample,
                        in_ch.end_of_block, in_ch.band, in_ch.coef_index,
                        in_ch.coef_value});
        in_beat_taken = 1'b1;
      end
    end
  end

  // Output monitor: each result beat against the oldest predicted frame
  always @(posedge clk) begin : check_out
    eq_frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frame_q.size() == 0) begin
        report_mismatch("result beat with no frame outstanding",
                        longint'(out_ch.left_out), 0);
      end else begin
        want = frame_q.pop_front();
        if (out_ch.left_out !== want.left)
          report_mismatch("left_out", longint'(out_ch.left_out), longint'(want.left));
        if (out_ch.right_out !== want.right)
          report_mismatch("right_out", longint'(out_ch.right_out), longint'(want.right));
        if (out_ch.last_of_block !== want.last)
          report_mismatch("last_of_block", longint'(out_ch.last_of_block),
                          longint'(want.last));
        frames_checked++;
      end
    end
  end

  // Sequence: reset, directed checks, then random phases over several settings
  initial begin : run
    int          p;
    bit          en;
    bit [NB-1:0] mask;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_FRAME;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.end_of_block = 1'b0;
    in_ch.band         = '0;
    in_ch.coef_index   = '0;
    in_ch.coef_value   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_EFFECT_ENABLE;
    cfg_ch.data        = '0;
    sink_pat           = '1;
    sink_left          = 0;
    burst_left         = 0;
    gap_left           = 0;
    in_beat_taken      = 1'b0;
    cfg_beats          = 0;
    mismatches         = 0;
    frames_checked     = 0;
    work_items         = 0;
    coef_writes        = 0;
    clears             = 0;
    ignored_items      = 0;
    reset_model();
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    write_setting(1'b1, '1);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

    // Directed: full-scale samples, extreme gains, ignored writes, feedback, clear
    add_item(frame_of(S_MAX, S_MIN, 1'b0));
    add_item(frame_of(S_MIN, S_MAX, 1'b1));
    add_item(frame_of(0, 0, 1'b0));
    add_item(coef_of(0, TAP_B0, C_MAX));
    add_item(frame_of(S_MAX, S_MIN, 1'b0));
    add_item(frame_of(3, -3, 1'b0));
    add_item(coef_of(0, TAP_B0, C_MIN));
    add_item(frame_of(S_MAX, S_MIN, 1'b1));
    add_item(frame_of(1, -1, 1'b0));
    add_item(coef_of(NB, TAP_B0, 0));
    add_item(coef_of(BAND_FLD_TOP, TAP_A2, C_MAX));
    add_item(coef_of(0, NUM_COEFS, 0));
    add_item(coef_of(0, TAP_FLD_TOP, C_MAX));
    add_item(blank_item(KIND_RSVD));
    add_item(coef_of(0, TAP_B0, ONE_Q));
    add_item(coef_of(NB - 1, TAP_B1, HALF_Q));
    add_item(coef_of(NB - 1, TAP_A1, -HALF_Q));
    add_item(coef_of(NB - 1, TAP_A2, C_MIN));
    add_item(frame_of(S_MAX, S_MIN, 1'b0));
    add_item(frame_of(1000, -1000, 1'b0));
    add_item(frame_of(0, 0, 1'b1));
    add_item(blank_item(KIND_CLEAR));
    add_item(frame_of(5, -5, 1'b0));
    add_item(coef_of(NB - 1, TAP_A2, 0));
    add_item(frame_of(S_MIN, S_MAX, 1'b1));
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin en = 1'b1; mask = '1; end
        1:       begin en = 1'b0; mask = '1; end
        2:       begin en = 1'b1; mask = '0; end
        3:       begin en = 1'b1; mask = 6'b101010; end
        4:       begin en = 1'b1; mask = NB'($urandom); end
        5:       begin en = 1'b0; mask = NB'($urandom); end
        default: begin en = 1'b1; mask = '1; end
      endcase
      write_setting(en, mask);
      random_phase(PHASE_ITEMS);
      drain();
    end

    $display("Run covered %0d frames checked, %0d coefficient writes and %0d clears",
             frames_checked, coef_writes, clears);
    $display("across %0d register settings, plus %0d beats the core should ignore.",
             NUM_PHASES + 1, ignored_items);
    if (mismatches == 0) begin
      $display("** stereo_cascaded_biquad_equalizer_core: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** stereo_cascaded_biquad_equalizer_core: FAILED **");
    end
    $finish;
  end

endmodule
